/* hw/rtl/golden_ratio_hue_palette_macros.svh */
// Assertion macros shared by the golden ratio hue palette RTL.
`ifndef GOLDEN_RATIO_HUE_PALETTE_MACROS_SVH
`define GOLDEN_RATIO_HUE_PALETTE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define GRHP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("grhp: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define GRHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("grhp: next-cycle check failed");
`else
`define GRHP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define GRHP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/grhp_pkg.sv */
// Package with types, constants and helper functions of the hue palette.
`default_nettype none

package grhp_pkg;

	// Palette geometry and hue stepping.
	localparam int IDX_W = 9;
	localparam int PALETTE_SIZE = 512;
	localparam int HUE_W = 16;
	localparam logic [HUE_W-1:0] HUE_STEP = 16'd40503;

	// Fraction widths: Q1.24 factors and Q0.32 channel values.
	localparam int FRAC_W = 25;
	localparam int VAL_W = 32;
	localparam logic [FRAC_W-1:0] FRAC_ONE = 25'h1000000;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_START_HUE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 2'd3;
	localparam int CFG_DATA_W = 16;

	// Hue sectors of the six-sector HSV rule.
	localparam logic [2:0] SECTOR_RED_YELLOW    = 3'd0;
	localparam logic [2:0] SECTOR_YELLOW_GREEN  = 3'd1;
	localparam logic [2:0] SECTOR_GREEN_CYAN    = 3'd2;
	localparam logic [2:0] SECTOR_CYAN_BLUE     = 3'd3;
	localparam logic [2:0] SECTOR_BLUE_MAGENTA  = 3'd4;

	// Current register settings.
	typedef struct packed {
		logic [HUE_W-1:0] start_hue;
		logic [7:0]       saturation;
		logic [7:0]       brightness;
		logic [7:0]       alpha;
	} cfg_t;

	// Hue sector and the three shading factors of one color.
	typedef struct packed {
		logic [2:0]        sector;
		logic [FRAC_W-1:0] p_frac;
		logic [FRAC_W-1:0] q_frac;
		logic [FRAC_W-1:0] t_frac;
	} shade_t;

	// Scales a Q1.24 factor by the Q0.8 value; the product stays below 2^32.
	function automatic logic [VAL_W-1:0] scale_by_value(input logic [FRAC_W-1:0] frac,
			input logic [7:0] value);
		logic [FRAC_W+7:0] prod;
		prod = {8'b0, frac} * {{FRAC_W{1'b0}}, value};
		return prod[VAL_W-1:0];
	endfunction

	// Turns a Q0.32 value into an 8-bit channel, times 255, rounded half up.
	function automatic logic [7:0] to_channel(input logic [VAL_W-1:0] x);
		logic [VAL_W+7:0] sum;
		sum = {x, 8'b0} - {8'b0, x} + {8'b0, 1'b1, {(VAL_W-1){1'b0}}};
		return sum[VAL_W+7:VAL_W];
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/golden_ratio_hue_palette.sv */
// Top level of the golden ratio hue palette: config registers and color pipeline.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    color_index
// out      output     out_valid / out_ready  red, green, blue, alpha_out
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One color per clock while the output is not stalled.
// Four register stages: hue step, sector and factors, value scaling, rounding.
// Reset clears all stage valid bits and loads the register defaults.
// A stalled output holds every stage that is full; empty stages still fill.
// Configuration writes never stall.
`default_nettype none

module golden_ratio_hue_palette
	import grhp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [IDX_W-1:0]      color_index,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [7:0]                 red,
	output logic [7:0]                 green,
	output logic [7:0]                 blue,
	output logic [7:0]                 alpha_out,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t   cfg;
	logic   shade_valid;
	logic   shade_ready;
	shade_t shade;

	// Register file.
	grhp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Hue and factor stages.
	grhp_hue u_hue (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.color_index (color_index),
		.shade_valid (shade_valid),
		.shade_ready (shade_ready),
		.shade       (shade)
	);

	// Scaling and rounding stages.
	grhp_shade u_shade (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.shade_valid (shade_valid),
		.shade_ready (shade_ready),
		.shade       (shade),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.red         (red),
		.green       (green),
		.blue        (blue)
	);

	// Alpha comes straight from its register.
	assign alpha_out = cfg.alpha;

endmodule

`default_nettype wire

/* hw/rtl/grhp_cfg.sv */
// Configuration registers of the hue palette.
`default_nettype none

module grhp_cfg
	import grhp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	// Writes never stall.
	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	// Register file, one write transaction per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_hue  <= '0;
			cfg_q.saturation <= 8'd204;
			cfg_q.brightness <= 8'd252;
			cfg_q.alpha      <= 8'd255;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_START_HUE:  cfg_q.start_hue  <= cfg_data;
				REG_SATURATION: cfg_q.saturation <= cfg_data[7:0];
				REG_BRIGHTNESS: cfg_q.brightness <= cfg_data[7:0];
				REG_ALPHA:      cfg_q.alpha      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/grhp_hue.sv */
// Hue stages: golden ratio hue stepping, then sector and shading factors.
`default_nettype none
`include "golden_ratio_hue_palette_macros.svh"

module grhp_hue
	import grhp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [IDX_W-1:0] color_index,
	output logic                  shade_valid,
	input  wire logic             shade_ready,
	output shade_t                shade
);

	logic             valid_s1;
	logic [HUE_W-1:0] h_s1;
	logic             valid_s2;
	shade_t           shade_s2;
	logic             ready_s1;
	logic             ready_s2;

	logic [IDX_W-1:0]       idx_n;
	logic [IDX_W:0]         idx_p1;
	logic [IDX_W+HUE_W:0]   step_prod;
	logic [HUE_W-1:0]       hue;
	logic [HUE_W+2:0]       h6;
	logic [HUE_W-1:0]       f;
	logic [HUE_W+7:0]       fs;
	logic [HUE_W:0]         f_inv;
	logic [HUE_W+8:0]       f_inv_s;
	shade_t                 shade_d;

	// A stage takes new data when it is empty or its contents move on.
	assign ready_s2 = !valid_s2 || shade_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// Stage 1: hue = start + (n + 1) * step, modulo one turn.
	always_comb begin
		idx_n     = IDX_W'(color_index % PALETTE_SIZE);
		idx_p1    = {1'b0, idx_n} + {{IDX_W{1'b0}}, 1'b1};
		step_prod = {{HUE_W{1'b0}}, idx_p1} * {{(IDX_W+1){1'b0}}, HUE_STEP};
		hue       = cfg.start_hue + step_prod[HUE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			h_s1 <= hue;
		end
	end

	// Stage 2: split hue * 6 into sector and fraction, form the factors.
	always_comb begin
		h6      = {2'b0, h_s1, 1'b0} + {1'b0, h_s1, 2'b0};
		f       = h6[HUE_W-1:0];
		fs      = {8'b0, f} * {{HUE_W{1'b0}}, cfg.saturation};
		f_inv   = {1'b1, {HUE_W{1'b0}}} - {1'b0, f};
		f_inv_s = {8'b0, f_inv} * {{(HUE_W+1){1'b0}}, cfg.saturation};
		shade_d.sector = h6[HUE_W+2:HUE_W];
		shade_d.p_frac = {9'd256 - {1'b0, cfg.saturation}, {HUE_W{1'b0}}};
		shade_d.q_frac = FRAC_ONE - {1'b0, fs};
		shade_d.t_frac = FRAC_ONE - f_inv_s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			shade_s2 <= shade_d;
		end
	end

	assign shade_valid = valid_s2;
	assign shade       = shade_s2;

	// A blocked first stage keeps its hue for the next cycle.
	`GRHP_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !ready_s2, valid_s1 && $stable(h_s1))

endmodule

`default_nettype wire

/* hw/rtl/grhp_shade.sv */
// Shading stages: sector routing with value scaling, then channel rounding.
`default_nettype none
`include "golden_ratio_hue_palette_macros.svh"

module grhp_shade
	import grhp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  shade_valid,
	output logic       shade_ready,
	input  wire shade_t shade,
	output logic       out_valid,
	input  wire logic  out_ready,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);

	// Largest product: full value times one.
	localparam logic [VAL_W-1:0] VAL_MAX = {8'hFF, 24'h0};

	logic             valid_s3;
	logic [VAL_W-1:0] r_s3;
	logic [VAL_W-1:0] g_s3;
	logic [VAL_W-1:0] b_s3;
	logic             valid_s4;
	logic [7:0]       red_s4;
	logic [7:0]       green_s4;
	logic [7:0]       blue_s4;
	logic             ready_s3;
	logic             ready_s4;

	logic [FRAC_W-1:0] r_frac;
	logic [FRAC_W-1:0] g_frac;
	logic [FRAC_W-1:0] b_frac;

	assign ready_s4    = !valid_s4 || out_ready;
	assign ready_s3    = !valid_s3 || ready_s4;
	assign shade_ready = ready_s3;

	// Stage 3: route the factors by sector; the largest channel gets one.
	always_comb begin
		case (shade.sector)
			SECTOR_RED_YELLOW: begin
				r_frac = FRAC_ONE;     g_frac = shade.t_frac; b_frac = shade.p_frac;
			end
			SECTOR_YELLOW_GREEN: begin
				r_frac = shade.q_frac; g_frac = FRAC_ONE;     b_frac = shade.p_frac;
			end
			SECTOR_GREEN_CYAN: begin
				r_frac = shade.p_frac; g_frac = FRAC_ONE;     b_frac = shade.t_frac;
			end
			SECTOR_CYAN_BLUE: begin
				r_frac = shade.p_frac; g_frac = shade.q_frac; b_frac = FRAC_ONE;
			end
			SECTOR_BLUE_MAGENTA: begin
				r_frac = shade.t_frac; g_frac = shade.p_frac; b_frac = FRAC_ONE;
			end
			default: begin
				r_frac = FRAC_ONE;     g_frac = shade.p_frac; b_frac = shade.q_frac;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= shade_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && shade_valid) begin
			r_s3 <= scale_by_value(r_frac, cfg.brightness);
			g_s3 <= scale_by_value(g_frac, cfg.brightness);
			b_s3 <= scale_by_value(b_frac, cfg.brightness);
		end
	end

	// Stage 4: scale to 0..255 with rounding; this is the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ready_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			red_s4   <= to_channel(r_s3);
			green_s4 <= to_channel(g_s3);
			blue_s4  <= to_channel(b_s3);
		end
	end

	assign out_valid = valid_s4;
	assign red       = red_s4;
	assign green     = green_s4;
	assign blue      = blue_s4;

	// A blocked third stage keeps its products.
	`GRHP_ASSERT_NEXT(a_s3_hold, clk, arst_n, valid_s3 && !ready_s4, valid_s3 && $stable(r_s3) && $stable(g_s3) && $stable(b_s3))
	// Value is below one, so a rounded channel never reaches full scale.
	`GRHP_ASSERT_IMPLY(a_chan_range, clk, arst_n, out_valid, red != 8'd255 && green != 8'd255 && blue != 8'd255)
	// A third-stage product never exceeds full value times one.
	`GRHP_ASSERT_IMPLY(a_prod_range, clk, arst_n, valid_s3, r_s3 <= VAL_MAX && g_s3 <= VAL_MAX && b_s3 <= VAL_MAX)

endmodule

`default_nettype wire

/* tb/sv/golden_ratio_hue_palette_checker.sv */
// Checker for the golden ratio hue palette: predicts each color and compares it on the way out.
`timescale 1ns / 1ps

module golden_ratio_hue_palette_checker
	import grhp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [IDX_W-1:0]      color_index,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [7:0]            red,
	input  logic [7:0]            green,
	input  logic [7:0]            blue,
	input  logic [7:0]            alpha_out,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending,
	output int                    checked
);

	// Register values after reset.
	localparam logic [15:0] RST_START_HUE  = 16'd0;
	localparam logic [7:0]  RST_SATURATION = 8'd204;
	localparam logic [7:0]  RST_BRIGHTNESS = 8'd252;
	localparam logic [7:0]  RST_ALPHA      = 8'd255;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_t;

	// Local copy of the register settings.
	logic [15:0] hue_offset;
	logic [7:0]  sat_level;
	logic [7:0]  value_level;
	logic [7:0]  alpha_level;

	rgba_t expected_colors[$];

	initial begin
		fail_count = 0;
		pending = 0;
		checked = 0;
	end

	// Scales a Q0.32 level to 0..255, rounding half up and clamping at the top.
	function automatic logic [7:0] level_to_byte(input logic [63:0] level);
		logic [63:0] scaled;
		scaled = (level * 64'd255 + 64'h8000_0000) >> 32;
		return (scaled > 64'd255) ? 8'd255 : scaled[7:0];
	endfunction

	// Hue of the palette entry, then the six-sector HSV conversion.
	function automatic rgba_t palette_color(input logic [IDX_W-1:0] idx,
			input logic [15:0] hue0, input logic [7:0] sat, input logic [7:0] val,
			input logic [7:0] alph);
		logic [63:0] entry;
		logic [63:0] hue;
		logic [63:0] hue6;
		logic [63:0] frac;
		logic [63:0] full;
		logic [63:0] v_lvl;
		logic [63:0] p_lvl;
		logic [63:0] q_lvl;
		logic [63:0] t_lvl;
		logic [63:0] r_lvl;
		logic [63:0] g_lvl;
		logic [63:0] b_lvl;
		logic [2:0]  sector;
		rgba_t       color;
		entry = 64'(idx) % 64'(PALETTE_SIZE);
		hue = (64'(hue0) + (entry + 64'd1) * 64'(HUE_STEP)) & 64'hFFFF;
		hue6 = hue * 64'd6;
		sector = hue6[18:16];
		frac = hue6 & 64'hFFFF;
		full = 64'd1 << 24;
		v_lvl = 64'(val) * full;
		p_lvl = 64'(val) * (full - 64'd65536 * 64'(sat));
		q_lvl = 64'(val) * (full - frac * 64'(sat));
		t_lvl = 64'(val) * (full - (64'd65536 - frac) * 64'(sat));
		case (sector)
			SECTOR_RED_YELLOW: begin
				r_lvl = v_lvl; g_lvl = t_lvl; b_lvl = p_lvl;
			end
			SECTOR_YELLOW_GREEN: begin
				r_lvl = q_lvl; g_lvl = v_lvl; b_lvl = p_lvl;
			end
			SECTOR_GREEN_CYAN: begin
				r_lvl = p_lvl; g_lvl = v_lvl; b_lvl = t_lvl;
			end
			SECTOR_CYAN_BLUE: begin
				r_lvl = p_lvl; g_lvl = q_lvl; b_lvl = v_lvl;
			end
			SECTOR_BLUE_MAGENTA: begin
				r_lvl = t_lvl; g_lvl = p_lvl; b_lvl = v_lvl;
			end
			default: begin
				r_lvl = v_lvl; g_lvl = p_lvl; b_lvl = q_lvl;
			end
		endcase
		color.red = level_to_byte(r_lvl);
		color.green = level_to_byte(g_lvl);
		color.blue = level_to_byte(b_lvl);
		color.alpha = alph;
		return color;
	endfunction

	// Reports one field that differs from its prediction.
	task automatic compare_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			fail_count++;
		end
	endtask

	// Track register writes, predict on input transactions, check output transactions.
	always @(posedge clk or negedge arst_n) begin
		rgba_t want;
		if (!arst_n) begin
			hue_offset = RST_START_HUE;
			sat_level = RST_SATURATION;
			value_level = RST_BRIGHTNESS;
			alpha_level = RST_ALPHA;
			expected_colors.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_colors.size() == 0) begin
					$display("%0t: unexpected color, expected none, actual %0d %0d %0d %0d",
						$time, red, green, blue, alpha_out);
					fail_count++;
				end else begin
					want = expected_colors.pop_front();
					compare_field("red", want.red, red);
					compare_field("green", want.green, green);
					compare_field("blue", want.blue, blue);
					compare_field("alpha_out", want.alpha, alpha_out);
					checked++;
				end
			end
			if (in_valid && in_ready)
				expected_colors.push_back(palette_color(color_index, hue_offset, sat_level,
					value_level, alpha_level));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_START_HUE:  hue_offset = cfg_data[15:0];
					REG_SATURATION: sat_level = cfg_data[7:0];
					REG_BRIGHTNESS: value_level = cfg_data[7:0];
					REG_ALPHA:      alpha_level = cfg_data[7:0];
					default: ;
				endcase
			end
		end
		pending = expected_colors.size();
	end

endmodule

/* tb/sv/tb_golden_ratio_hue_palette.sv */
// Top of the golden ratio hue palette testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_golden_ratio_hue_palette;
	import grhp_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_PHASES = 16;
	localparam int PHASE_ITEMS = 100;
	localparam int SETTLE_CYCLES = 10;

	typedef enum {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_STEADY} rx_mode_e;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [IDX_W-1:0]      color_index = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [7:0]            red;
	logic [7:0]            green;
	logic [7:0]            blue;
	logic [7:0]            alpha_out;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int fail_count;
	int pending;
	int checked;
	int colors_sent = 0;
	int settings_used = 0;
	int idle_cycles = 0;
	rx_mode_e rx_mode = RX_OPEN;
	int rx_left = 0;
	int rx_tick = 0;

	golden_ratio_hue_palette i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.color_index(color_index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.alpha_out  (alpha_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	golden_ratio_hue_palette_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.color_index(color_index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.alpha_out  (alpha_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// The color receiver switches between open, random, sparse and steady stall patterns.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_e'($urandom_range(0, 3));
			rx_left = $urandom_range(16, 200);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			RX_OPEN:   out_ready <= 1'b1;
			RX_RANDOM: out_ready <= ($urandom_range(0, 1) == 1);
			RX_SPARSE: out_ready <= (rx_tick % 8 == 0);
			default:   out_ready <= (rx_tick % 3 != 0);
		endcase
	end

	// Watchdog: ends the run when no transaction happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("tb_golden_ratio_hue_palette failed");
			$finish;
		end
	end

	// Presents one palette index and holds it until the transaction completes.
	task automatic send_color(input logic [IDX_W-1:0] idx);
		in_valid <= 1'b1;
		color_index <= idx;
		do @(posedge clk); while (!in_ready);
		colors_sent++;
	endtask

	// Gap between bursts.
	task automatic pause_sender(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Stops sending and waits until every predicted color has come out.
	task automatic drain_colors();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Writes all four registers while the block is idle.
	task automatic set_palette(input logic [15:0] hue_word, input logic [15:0] sat_word,
			input logic [15:0] bright_word, input logic [15:0] alpha_word);
		drain_colors();
		write_reg(REG_START_HUE, hue_word);
		write_reg(REG_SATURATION, sat_word);
		write_reg(REG_BRIGHTNESS, bright_word);
		write_reg(REG_ALPHA, alpha_word);
		settings_used++;
	endtask

	// Register value biased toward its extremes.
	function automatic logic [15:0] pick_setting(input logic [15:0] top);
		case ($urandom_range(0, 5))
			0:       return 16'd0;
			1:       return top;
			default: return 16'($urandom_range(0, top));
		endcase
	endfunction

	// An 8-bit register value with random junk in the upper byte.
	function automatic logic [15:0] byte_word(input logic [7:0] value);
		return {8'($urandom_range(0, 255)), value};
	endfunction

	function automatic logic [IDX_W-1:0] pick_index();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			default: return IDX_W'($urandom_range(0, PALETTE_SIZE - 1));
		endcase
	endfunction

	initial begin
		logic [IDX_W-1:0] reset_indexes[$];
		logic [IDX_W-1:0] corner_indexes[$];
		int remaining;
		int burst;
		bit no_gaps;
		reset_indexes = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd255, 9'd256,
			9'd510, 9'd511, 9'h155, 9'h0AA};
		corner_indexes = '{9'd0, 9'd511, 9'd1, 9'd100, 9'd300};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings first, then the register extremes with junk upper bits.
		foreach (reset_indexes[i]) send_color(reset_indexes[i]);
		set_palette(16'hFFFF, 16'hA5FF, 16'h5AFF, 16'hFF00);
		foreach (corner_indexes[i]) send_color(corner_indexes[i]);
		set_palette(16'h0000, 16'hFF00, 16'hFF00, 16'h00FF);
		foreach (corner_indexes[i]) send_color(corner_indexes[i]);

		// Random phases, each with its own settings and burst shape.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			set_palette(pick_setting(16'hFFFF), byte_word(8'(pick_setting(16'hFF))),
				byte_word(8'(pick_setting(16'hFF))), byte_word(8'(pick_setting(16'hFF))));
			no_gaps = ($urandom_range(0, 3) == 0);
			remaining = PHASE_ITEMS;
			while (remaining > 0) begin
				burst = $urandom_range(1, 40);
				if (burst > remaining)
					burst = remaining;
				repeat (burst) send_color(pick_index());
				remaining -= burst;
				if ($urandom_range(0, 15) == 0)
					drain_colors();
				else if (!no_gaps)
					pause_sender($urandom_range(1, 20));
			end
		end

		drain_colors();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d palette indexes under %0d register settings; %0d colors compared.",
			colors_sent, settings_used, checked);
		if (fail_count == 0) begin
			$display("tb_golden_ratio_hue_palette passed");
		end else begin
			$display("tb_golden_ratio_hue_palette failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/grhp_pkg.sv
hw/rtl/grhp_cfg.sv
hw/rtl/grhp_hue.sv
hw/rtl/grhp_shade.sv
hw/rtl/golden_ratio_hue_palette.sv
tb/sv/golden_ratio_hue_palette_checker.sv
tb/sv/tb_golden_ratio_hue_palette.sv
